// File: rtl/riff_wav_stream_parser_core_defines.svh
// Assertion macros used by the parser controller
`ifndef RIFF_WAV_STREAM_PARSER_CORE_DEFINES_SVH
`define RIFF_WAV_STREAM_PARSER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RWSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RWSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rwsp_pkg.sv
// Shared types and constants of the RIFF/WAVE stream parser
`timescale 1ns / 1ps
package rwsp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FORMAT_PCM    = 16'd1;
    localparam logic [15:0] CHANNELS_MONO = 16'd1;
    localparam logic [15:0] BITS_8        = 16'd8;
    localparam logic [15:0] BITS_16       = 16'd16;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_INFO  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NOT_WAV    = 3'd0;
    localparam logic [2:0] ERR_NOT_PCM    = 3'd1;
    localparam logic [2:0] ERR_NOT_MONO   = 3'd2;
    localparam logic [2:0] ERR_BAD_BITS   = 3'd3;
    localparam logic [2:0] ERR_NO_FMT     = 3'd4;
    localparam logic [2:0] ERR_ZERO_ALIGN = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd6;

    localparam int IDX_W = 4;

    typedef struct packed {
        logic             tag_shift;
        logic             len_shift;
        logic             load_left;
        logic             dec_left;
        logic             fmt_wr;
        logic [IDX_W-1:0] fmt_index;
        logic             div_start;
        logic             out_load;
        logic [1:0]       out_kind;
        logic [2:0]       err_code;
        logic             last;
    } rwsp_cmd_t;

    typedef struct packed {
        logic tag_new_riff;
        logic tag_new_wave;
        logic tag_fmt;
        logic tag_data;
        logic len_new_zero;
        logic len_zero;
        logic left_dec_zero;
        logic pcm_ok;
        logic mono_ok;
        logic bits_ok;
        logic align_zero;
        logic div_busy;
        logic out_free;
    } rwsp_status_t;

endpackage

// File: rtl/rwsp_in_if.sv
// Byte stream channel carrying the WAV file image
`timescale 1ns / 1ps
interface rwsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_file;

    modport source (output valid, output in_byte, output end_of_file, input ready);
    modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

// File: rtl/rwsp_out_if.sv
// Result channel carrying sample bytes, format info and error codes
`timescale 1ns / 1ps
interface rwsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  sample_byte;
    logic [4:0]  bits_per_sample;
    logic [31:0] sample_rate;
    logic [31:0] sample_count;
    logic [2:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output sample_byte, output bits_per_sample,
                    output sample_rate, output sample_count, output error_code,
                    output last, input ready);
    modport sink   (input valid, input kind, input sample_byte, input bits_per_sample,
                    input sample_rate, input sample_count, input error_code,
                    input last, output ready);
endinterface

// File: rtl/rwsp_div.sv
// Bit-serial restoring divider: 32-bit length by 16-bit block align
`timescale 1ns / 1ps
module rwsp_div
    import rwsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);

    localparam logic [5:0] DIV_STEPS = 6'd32;

    logic [31:0] quo_reg;
    logic [15:0] rem_reg;
    logic [5:0]  count_reg;
    logic        busy_reg;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    assign trial = {rem_reg, quo_reg[31]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= DIV_STEPS;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - 6'd1;
            if (count_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[30:0], ge};
            rem_reg <= ge ? diff[15:0] : trial[15:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/rwsp_datapath.sv
// Datapath: chunk tag and length shifters, fmt fields, divider, result register
`timescale 1ns / 1ps
module rwsp_datapath
    import rwsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        in_byte,
    input  rwsp_cmd_t         cmd,
    output rwsp_status_t      st,
    rwsp_out_if.source        result_stream
);

    logic [31:0] chunk_tag_reg;
    logic [31:0] chunk_length_reg;
    logic [31:0] bytes_left_reg;
    logic [15:0] format_tag_reg;
    logic [15:0] channel_count_reg;
    logic [31:0] rate_value_reg;
    logic [15:0] block_align_reg;
    logic [15:0] sample_bits_reg;

    logic [31:0] tag_shifted;
    logic [31:0] len_shifted;
    logic [15:0] bits_new;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  sample_byte_reg;
    logic [4:0]  bits_reg;
    logic [31:0] rate_reg;
    logic [31:0] count_reg;
    logic [2:0]  error_code_reg;
    logic        last_reg;

    logic        div_busy;
    logic [31:0] quotient;

    assign tag_shifted = {in_byte, chunk_tag_reg[31:8]};
    assign len_shifted = {in_byte, chunk_length_reg[31:8]};
    assign bits_new    = {in_byte, sample_bits_reg[7:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_tag_reg    <= '0;
            chunk_length_reg <= '0;
            bytes_left_reg   <= '0;
        end
        else
        begin
            if (cmd.tag_shift)
            begin
                chunk_tag_reg <= tag_shifted;
            end
            if (cmd.len_shift)
            begin
                chunk_length_reg <= len_shifted;
            end
            if (cmd.load_left)
            begin
                bytes_left_reg <= len_shifted;
            end
            else if (cmd.dec_left && bytes_left_reg != 32'd0)
            begin
                bytes_left_reg <= bytes_left_reg - 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_tag_reg    <= '0;
            channel_count_reg <= '0;
            rate_value_reg    <= '0;
            block_align_reg   <= '0;
            sample_bits_reg   <= '0;
        end
        else if (cmd.fmt_wr)
        begin
            case (cmd.fmt_index)
                4'd0:
                begin
                    format_tag_reg    <= {8'h00, in_byte};
                    channel_count_reg <= '0;
                    rate_value_reg    <= '0;
                    block_align_reg   <= '0;
                    sample_bits_reg   <= '0;
                end
                4'd1:  format_tag_reg[15:8]    <= in_byte;
                4'd2:  channel_count_reg[7:0]  <= in_byte;
                4'd3:  channel_count_reg[15:8] <= in_byte;
                4'd4:  rate_value_reg[7:0]     <= in_byte;
                4'd5:  rate_value_reg[15:8]    <= in_byte;
                4'd6:  rate_value_reg[23:16]   <= in_byte;
                4'd7:  rate_value_reg[31:24]   <= in_byte;
                4'd12: block_align_reg[7:0]    <= in_byte;
                4'd13: block_align_reg[15:8]   <= in_byte;
                4'd14: sample_bits_reg[7:0]    <= in_byte;
                4'd15: sample_bits_reg[15:8]   <= in_byte;
                default: ;
            endcase
        end
    end

    rwsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (len_shifted),
        .divisor  (block_align_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_stream.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            kind_reg        <= cmd.out_kind;
            sample_byte_reg <= (cmd.out_kind == KIND_DATA) ? in_byte : 8'h00;
            bits_reg        <= (cmd.out_kind == KIND_INFO) ? sample_bits_reg[4:0] : 5'd0;
            rate_reg        <= (cmd.out_kind == KIND_INFO) ? rate_value_reg : 32'd0;
            count_reg       <= (cmd.out_kind == KIND_INFO) ? quotient : 32'd0;
            error_code_reg  <= (cmd.out_kind == KIND_ERROR) ? cmd.err_code : 3'd0;
            last_reg        <= cmd.last;
        end
    end

    always_comb
    begin
        st.tag_new_riff  = (tag_shifted == TAG_RIFF);
        st.tag_new_wave  = (tag_shifted == TAG_WAVE);
        st.tag_fmt       = (chunk_tag_reg == TAG_FMT);
        st.tag_data      = (chunk_tag_reg == TAG_DATA);
        st.len_new_zero  = (len_shifted == 32'd0);
        st.len_zero      = (chunk_length_reg == 32'd0);
        st.left_dec_zero = (bytes_left_reg[31:1] == 31'd0);
        st.pcm_ok        = (format_tag_reg == FORMAT_PCM);
        st.mono_ok       = (channel_count_reg == CHANNELS_MONO);
        st.bits_ok       = (bits_new == BITS_8) || (bits_new == BITS_16);
        st.align_zero    = (block_align_reg == 16'd0);
        st.div_busy      = div_busy;
        st.out_free      = !out_valid_reg || result_stream.ready;
    end

    assign result_stream.valid           = out_valid_reg;
    assign result_stream.kind            = kind_reg;
    assign result_stream.sample_byte     = sample_byte_reg;
    assign result_stream.bits_per_sample = bits_reg;
    assign result_stream.sample_rate     = rate_reg;
    assign result_stream.sample_count    = count_reg;
    assign result_stream.error_code      = error_code_reg;
    assign result_stream.last            = last_reg;

endmodule

// File: rtl/rwsp_ctrl.sv
// Controller: parse phase state machine, byte index and fmt-seen flag
`timescale 1ns / 1ps
`include "riff_wav_stream_parser_core_defines.svh"
module rwsp_ctrl
    import rwsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rwsp_in_if.sink      file_stream,
    input  rwsp_status_t st,
    output rwsp_cmd_t    cmd
);

    localparam logic [2:0] ST_RIFF = 3'd0;
    localparam logic [2:0] ST_HDR  = 3'd1;
    localparam logic [2:0] ST_FMT  = 3'd2;
    localparam logic [2:0] ST_SKIP = 3'd3;
    localparam logic [2:0] ST_DATA = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam logic [IDX_W-1:0] IDX_RIFF_TAG = 4'd3;
    localparam logic [IDX_W-1:0] IDX_WAVE_TAG = 4'd11;
    localparam logic [IDX_W-1:0] IDX_HDR_LEN  = 4'd4;
    localparam logic [IDX_W-1:0] IDX_HDR_LAST = 4'd7;
    localparam logic [IDX_W-1:0] IDX_FMT_LAST = 4'd15;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             fmt_seen_reg;
    logic             fmt_seen_next;

    logic             fire;
    logic             fail;
    logic [2:0]       fail_code;
    logic             fin;
    logic             go_div;

    assign file_stream.ready = (state_reg == ST_DONE) ||
                               ((state_reg != ST_DIV) && st.out_free);
    assign fire = file_stream.valid && file_stream.ready;

    always_comb
    begin
        cmd           = '0;
        cmd.fmt_index = idx_reg;
        state_next    = state_reg;
        idx_next      = idx_reg;
        fmt_seen_next = fmt_seen_reg;
        fail          = 1'b0;
        fail_code     = ERR_NOT_WAV;
        fin           = 1'b0;
        go_div        = 1'b0;

        if (fire)
        begin
            case (state_reg)
                ST_RIFF:
                begin
                    cmd.tag_shift = 1'b1;
                    if (idx_reg == IDX_RIFF_TAG && !st.tag_new_riff)
                    begin
                        fail = 1'b1;
                    end
                    else if (idx_reg == IDX_WAVE_TAG)
                    begin
                        if (!st.tag_new_wave)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_HDR;
                            idx_next   = '0;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
                ST_HDR:
                begin
                    cmd.tag_shift = (idx_reg < IDX_HDR_LEN);
                    cmd.len_shift = (idx_reg >= IDX_HDR_LEN);
                    if (idx_reg != IDX_HDR_LAST)
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                    else
                    begin
                        idx_next      = '0;
                        cmd.load_left = 1'b1;
                        if (st.tag_fmt)
                        begin
                            state_next = ST_FMT;
                        end
                        else if (st.tag_data)
                        begin
                            if (!fmt_seen_reg)
                            begin
                                fail      = 1'b1;
                                fail_code = ERR_NO_FMT;
                            end
                            else if (st.align_zero)
                            begin
                                fail      = 1'b1;
                                fail_code = ERR_ZERO_ALIGN;
                            end
                            else
                            begin
                                go_div = 1'b1;
                                fin    = st.len_new_zero;
                            end
                        end
                        else if (!st.len_new_zero)
                        begin
                            state_next = ST_SKIP;
                        end
                    end
                end
                ST_FMT:
                begin
                    cmd.fmt_wr   = 1'b1;
                    cmd.dec_left = 1'b1;
                    if (idx_reg == '0)
                    begin
                        fmt_seen_next = 1'b0;
                    end
                    if (idx_reg != IDX_FMT_LAST)
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                    else
                    begin
                        idx_next = '0;
                        if (!st.pcm_ok)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_NOT_PCM;
                        end
                        else if (!st.mono_ok)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_NOT_MONO;
                        end
                        else if (!st.bits_ok)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_BAD_BITS;
                        end
                        else
                        begin
                            fmt_seen_next = 1'b1;
                            state_next    = st.left_dec_zero ? ST_HDR : ST_SKIP;
                        end
                    end
                end
                ST_SKIP:
                begin
                    cmd.dec_left = 1'b1;
                    if (st.left_dec_zero)
                    begin
                        state_next = ST_HDR;
                        idx_next   = '0;
                    end
                end
                ST_DATA:
                begin
                    cmd.dec_left = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_DATA;
                    cmd.last     = st.left_dec_zero;
                    if (st.left_dec_zero)
                    begin
                        fin        = 1'b1;
                        state_next = ST_DONE;
                    end
                end
                default: ;
            endcase

            if (state_reg != ST_DONE && file_stream.end_of_file && !fail && !fin)
            begin
                fail      = 1'b1;
                fail_code = ERR_TRUNCATED;
            end

            if (fail)
            begin
                cmd.out_load = 1'b1;
                cmd.out_kind = KIND_ERROR;
                cmd.err_code = fail_code;
                cmd.last     = 1'b1;
                state_next   = ST_DONE;
            end
            else if (go_div)
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
        end
        else if (state_reg == ST_DIV && !st.div_busy && st.out_free)
        begin
            cmd.out_load = 1'b1;
            cmd.out_kind = KIND_INFO;
            cmd.last     = st.len_zero;
            state_next   = st.len_zero ? ST_DONE : ST_DATA;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RIFF;
            idx_reg      <= '0;
            fmt_seen_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            fmt_seen_reg <= fmt_seen_next;
        end
    end

    `RWSP_ASSERT_NEXT(a_div_start_busy, cmd.div_start, st.div_busy && state_reg == ST_DIV, "divider not running after start")
    `RWSP_ASSERT_NOW(a_load_when_free, cmd.out_load, st.out_free, "result register overwritten while held")
    `RWSP_ASSERT_NEXT(a_done_sticks, state_reg == ST_DONE, state_reg == ST_DONE, "parser left finished state")

endmodule

// File: rtl/riff_wav_stream_parser_core.sv
// Top level of the RIFF/WAVE PCM stream parser
`timescale 1ns / 1ps
// Usage:
// file_stream takes the WAV image one byte per request, end_of_file set on
// the final byte. result_stream gives sample data bytes, one format info
// request at the data chunk header, or one error code; last marks the end.
// Header and chunk bytes are taken one per cycle. A data byte or an error
// shows on result_stream in the cycle after its byte is taken. At the data
// chunk header the sample count comes from a bit-serial divider (one
// quotient bit per cycle), so the info request is loaded only once the divider
// is done, and file_stream is held off until then.
// The result register lets the next byte in while a result waits, as long
// as result_stream.ready is high in that cycle; with ready low, file_stream
// stalls until the waiting result is taken.
// After the last data byte, a final info request or an error, all further
// bytes are taken and dropped with no result until reset.
// Reset (rst_n low, asynchronous) returns to the RIFF tag check and forgets
// any format seen; no result is pending after reset.
module riff_wav_stream_parser_core
    import rwsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rwsp_in_if.sink      file_stream,
    rwsp_out_if.source   result_stream
);

    rwsp_cmd_t    cmd;
    rwsp_status_t st;

    rwsp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .file_stream (file_stream),
        .st          (st),
        .cmd         (cmd)
    );

    rwsp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_byte       (file_stream.in_byte),
        .cmd           (cmd),
        .st            (st),
        .result_stream (result_stream)
    );

endmodule

// File: tb/sv/riff_wav_stream_parser_core_test.sv
// Self-checking testbench for the RIFF/WAVE PCM stream parser core
`timescale 1ns / 1ps
module riff_wav_stream_parser_core_test;
    import rwsp_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int SETTLE_TICKS = 40;

    typedef enum logic [2:0] {
        P_TAGS,
        P_CHUNK_HEAD,
        P_FORMAT,
        P_SKIP,
        P_SAMPLES
    } parse_phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  sample_byte;
        logic [4:0]  bits_per_sample;
        logic [31:0] sample_rate;
        logic [31:0] sample_count;
        logic [2:0]  error_code;
        logic        last;
    } wav_result_t;

    logic clk;
    logic rst_n;

    rwsp_in_if  file_if ();
    rwsp_out_if result_if ();

    riff_wav_stream_parser_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .file_stream   (file_if),
        .result_stream (result_if)
    );

    parse_phase_t prs_phase    = P_TAGS;
    logic [4:0]   prs_index    = '0;
    logic [31:0]  prs_tag      = '0;
    logic [31:0]  prs_length   = '0;
    logic [31:0]  prs_left     = '0;
    logic [15:0]  fmt_tag      = '0;
    logic [15:0]  fmt_channels = '0;
    logic [31:0]  fmt_rate     = '0;
    logic [15:0]  fmt_align    = '0;
    logic [15:0]  fmt_bits     = '0;
    logic         fmt_valid    = 1'b0;
    logic         prs_done     = 1'b0;

    wav_result_t expected_results[$];

    int send_idle_pct  = 30;
    int recv_idle_pct  = 49;
    int cycle_count    = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int data_seen      = 0;
    int info_seen      = 0;
    int errors_seen    = 0;
    int mismatch_count = 0;
    int data_length    = 0;
    bit full_data      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic wav_result_t error_result(input logic [2:0] code);
        wav_result_t r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        r.last       = 1'b1;
        return r;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic eof);
        wav_result_t r;
        logic        hit;
        int          k;
        r   = '0;
        hit = 1'b0;
        k   = int'(prs_index);
        if (prs_done)
            return;
        case (prs_phase)
            P_TAGS:
            begin
                prs_tag = {b, prs_tag[31:8]};
                if (k == 3 && prs_tag != TAG_RIFF)
                begin
                    r   = error_result(ERR_NOT_WAV);
                    hit = 1'b1;
                end
                else if (k == 11)
                begin
                    if (prs_tag != TAG_WAVE)
                    begin
                        r   = error_result(ERR_NOT_WAV);
                        hit = 1'b1;
                    end
                    else
                    begin
                        prs_phase = P_CHUNK_HEAD;
                        prs_index = '0;
                    end
                end
                else
                    prs_index = prs_index + 5'd1;
            end
            P_CHUNK_HEAD:
            begin
                if (k < 4)
                    prs_tag = {b, prs_tag[31:8]};
                else
                    prs_length = {b, prs_length[31:8]};
                if (k < 7)
                    prs_index = prs_index + 5'd1;
                else
                begin
                    prs_index = '0;
                    prs_left  = prs_length;
                    if (prs_tag == TAG_FMT)
                        prs_phase = P_FORMAT;
                    else if (prs_tag == TAG_DATA)
                    begin
                        if (!fmt_valid)
                        begin
                            r   = error_result(ERR_NO_FMT);
                            hit = 1'b1;
                        end
                        else if (fmt_align == '0)
                        begin
                            r   = error_result(ERR_ZERO_ALIGN);
                            hit = 1'b1;
                        end
                        else
                        begin
                            r.kind            = KIND_INFO;
                            r.bits_per_sample = fmt_bits[4:0];
                            r.sample_rate     = fmt_rate;
                            r.sample_count    = prs_length / {16'd0, fmt_align};
                            r.last            = (prs_length == '0);
                            hit               = 1'b1;
                            if (prs_length == '0)
                                prs_done = 1'b1;
                            else
                                prs_phase = P_SAMPLES;
                        end
                    end
                    else if (prs_length != '0)
                        prs_phase = P_SKIP;
                end
            end
            P_FORMAT:
            begin
                if (k == 0)
                begin
                    fmt_tag      = '0;
                    fmt_channels = '0;
                    fmt_rate     = '0;
                    fmt_align    = '0;
                    fmt_bits     = '0;
                    fmt_valid    = 1'b0;
                end
                if (k < 2)
                    fmt_tag[8*k +: 8] = b;
                else if (k < 4)
                    fmt_channels[8*(k-2) +: 8] = b;
                else if (k < 8)
                    fmt_rate[8*(k-4) +: 8] = b;
                else if (k >= 12 && k < 14)
                    fmt_align[8*(k-12) +: 8] = b;
                else if (k >= 14)
                    fmt_bits[8*(k-14) +: 8] = b;
                if (prs_left != '0)
                    prs_left = prs_left - 32'd1;
                if (k < 15)
                    prs_index = prs_index + 5'd1;
                else
                begin
                    prs_index = '0;
                    if (fmt_tag != FORMAT_PCM)
                    begin
                        r   = error_result(ERR_NOT_PCM);
                        hit = 1'b1;
                    end
                    else if (fmt_channels != CHANNELS_MONO)
                    begin
                        r   = error_result(ERR_NOT_MONO);
                        hit = 1'b1;
                    end
                    else if (fmt_bits != BITS_8 && fmt_bits != BITS_16)
                    begin
                        r   = error_result(ERR_BAD_BITS);
                        hit = 1'b1;
                    end
                    else
                    begin
                        fmt_valid = 1'b1;
                        prs_phase = (prs_left != '0) ? P_SKIP : P_CHUNK_HEAD;
                    end
                end
            end
            P_SKIP:
            begin
                if (prs_left != '0)
                    prs_left = prs_left - 32'd1;
                if (prs_left == '0)
                begin
                    prs_phase = P_CHUNK_HEAD;
                    prs_index = '0;
                end
            end
            P_SAMPLES:
            begin
                if (prs_left != '0)
                    prs_left = prs_left - 32'd1;
                r.kind        = KIND_DATA;
                r.sample_byte = b;
                r.last        = (prs_left == '0);
                hit           = 1'b1;
                if (prs_left == '0)
                    prs_done = 1'b1;
            end
            default: ;
        endcase
        if (hit && r.kind == KIND_ERROR)
            prs_done = 1'b1;
        if (eof && !prs_done)
        begin
            r        = error_result(ERR_TRUNCATED);
            hit      = 1'b1;
            prs_done = 1'b1;
        end
        if (hit)
            expected_results.push_back(r);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            file_if.valid <= 1'b0;
            @(posedge clk);
        end
        file_if.valid       <= 1'b1;
        file_if.in_byte     <= b;
        file_if.end_of_file <= eof;
        @(posedge clk);
        while (!file_if.ready)
            @(posedge clk);
        items_sent++;
        predict_byte(b, eof);
    endtask

    task automatic send_le(input logic [31:0] value, input int count);
        for (int n = 0; n < count; n++)
            send_byte(value[8*n +: 8], 1'b0);
    endtask

    task automatic wait_for_results();
        file_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic send_format_chunk(input logic [31:0] length, input logic [31:0] rate,
                                     input logic [15:0] align, input logic [15:0] bits);
        send_le(TAG_FMT, 4);
        send_le(length, 4);
        send_le(32'(FORMAT_PCM), 2);
        send_le(32'(CHANNELS_MONO), 2);
        send_le(rate, 4);
        send_le($urandom, 4);
        send_le(32'(align), 2);
        send_le(32'(bits), 2);
        for (int n = 16; n < length; n++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic test_file_tags();
        send_le(TAG_RIFF, 4);
        send_le({8'hFF, 8'h00, 16'($urandom)}, 4);
        send_le(TAG_WAVE, 4);
    endtask

    task automatic test_unknown_chunks();
        logic [31:0] tag;
        int          length;
        do
            tag = $urandom;
        while (tag == TAG_FMT || tag == TAG_DATA);
        send_le(tag, 4);
        send_le(32'd0, 4);
        do
            tag = $urandom;
        while (tag == TAG_FMT || tag == TAG_DATA);
        length = $urandom_range(1, 6);
        send_le(tag, 4);
        send_le(length, 4);
        for (int n = 0; n < length; n++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_format_chunks();
        logic [15:0] align;
        align = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(5, 16'hFFFF))
                                             : 16'($urandom_range(1, 4));
        send_format_chunk(32'd10, 32'hFFFF_FFFF, 16'hFFFF, BITS_16);
        send_format_chunk(32'd16, 32'd0, 16'd1, BITS_8);
        send_format_chunk(32'd16 + $urandom_range(1, 8), $urandom, align,
                          $urandom_range(0, 1) ? BITS_16 : BITS_8);
    endtask

    task automatic test_sample_stream();
        int stop;
        data_length = $urandom_range(280, 320);
        full_data   = 1'($urandom_range(0, 1));
        stop        = full_data ? data_length : data_length - $urandom_range(1, 20);
        send_le(TAG_DATA, 4);
        send_le(data_length, 4);
        for (int n = 0; n < stop; n++)
        begin
            if (n == stop / 3)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 30;
                wait_for_results();
            end
            if (n == 2 * stop / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_byte(8'($urandom_range(0, 255)), n == stop - 1);
        end
    endtask

    task automatic test_ignored_after_finish();
        for (int n = 0; n < 10; n++)
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        wav_result_t got;
        wav_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got.kind            = result_if.kind;
            got.sample_byte     = result_if.sample_byte;
            got.bits_per_sample = result_if.bits_per_sample;
            got.sample_rate     = result_if.sample_rate;
            got.sample_count    = result_if.sample_count;
            got.error_code      = result_if.error_code;
            got.last            = result_if.last;
            results_seen++;
            case (got.kind)
                KIND_DATA:  data_seen++;
                KIND_INFO:  info_seen++;
                KIND_ERROR: errors_seen++;
                default: ;
            endcase
            if (expected_results.size() == 0)
                report_mismatch("unexpected result kind", 32'(got.kind), '0);
            else
            begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", 32'(got.kind), 32'(want.kind));
                if (got.sample_byte !== want.sample_byte)
                    report_mismatch("sample_byte", 32'(got.sample_byte),
                                    32'(want.sample_byte));
                if (got.bits_per_sample !== want.bits_per_sample)
                    report_mismatch("bits_per_sample", 32'(got.bits_per_sample),
                                    32'(want.bits_per_sample));
                if (got.sample_rate !== want.sample_rate)
                    report_mismatch("sample_rate", got.sample_rate, want.sample_rate);
                if (got.sample_count !== want.sample_count)
                    report_mismatch("sample_count", got.sample_count, want.sample_count);
                if (got.error_code !== want.error_code)
                    report_mismatch("error_code", 32'(got.error_code),
                                    32'(want.error_code));
                if (got.last !== want.last)
                    report_mismatch("last", 32'(got.last), 32'(want.last));
            end
        end
    end

    initial
    begin
        rst_n               <= 1'b0;
        file_if.valid       <= 1'b0;
        file_if.in_byte     <= '0;
        file_if.end_of_file <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_file_tags();
        test_unknown_chunks();
        test_format_chunks();
        test_sample_stream();
        test_ignored_after_finish();

        wait_for_results();
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("Sent %0d bytes: tags, empty and unknown chunks, short, exact and long fmt,",
                 items_sent);
        $display("and a %0d-byte data chunk (%0s); results %0d data, %0d info, %0d error",
                 data_length, full_data ? "complete" : "truncated",
                 data_seen, info_seen, errors_seen);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
